[design/dop_pkg.sv]
// Shared types and constants for the DHCP option parser.
`default_nettype none
package dop_pkg;

	typedef enum logic [1:0] {
		PH_CODE,
		PH_LEN,
		PH_VALUE,
		PH_DONE
	} phase_t;

	// Record kinds on the output.
	localparam logic [3:0] KIND_MASK     = 4'd0;
	localparam logic [3:0] KIND_GATEWAY  = 4'd1;
	localparam logic [3:0] KIND_NSERVER  = 4'd2;
	localparam logic [3:0] KIND_HOSTCHAR = 4'd3;
	localparam logic [3:0] KIND_DOMCHAR  = 4'd4;
	localparam logic [3:0] KIND_LEASE    = 4'd5;
	localparam logic [3:0] KIND_MSGTYPE  = 4'd6;
	localparam logic [3:0] KIND_SERVER   = 4'd7;
	localparam logic [3:0] KIND_RENEWAL  = 4'd8;
	localparam logic [3:0] KIND_REBIND   = 4'd9;
	localparam logic [3:0] KIND_END      = 4'd10;

	// Option codes.
	localparam logic [7:0] OPT_PAD      = 8'd0;
	localparam logic [7:0] OPT_MASK     = 8'd1;
	localparam logic [7:0] OPT_GATEWAY  = 8'd3;
	localparam logic [7:0] OPT_NSERVER  = 8'd6;
	localparam logic [7:0] OPT_HOSTNAME = 8'd12;
	localparam logic [7:0] OPT_DOMAIN   = 8'd15;
	localparam logic [7:0] OPT_LEASE    = 8'd51;
	localparam logic [7:0] OPT_MSGTYPE  = 8'd53;
	localparam logic [7:0] OPT_SERVER   = 8'd54;
	localparam logic [7:0] OPT_RENEWAL  = 8'd58;
	localparam logic [7:0] OPT_REBIND   = 8'd59;
	localparam logic [7:0] OPT_END      = 8'd255;

	localparam logic [31:0] TIME_SAT = 32'h0000_FFFF;

	// Output queue geometry.
	localparam int QDepth = 4;
	localparam int QAw    = 2;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] value;
		logic        inf;
		logic        saw;
	} rec_t;

	typedef struct packed {
		logic [1:0] cnt;
		rec_t       r0;
		rec_t       r1;
	} push_t;

endpackage
`default_nettype wire

[design/dop_fifo.sv]
// Output queue of parsed records, taking up to two records per cycle.
`default_nettype none
module dop_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire dop_pkg::push_t push,
	input  wire logic          pop,
	output dop_pkg::rec_t      head,
	output logic               not_empty,
	output logic               room2
);

	dop_pkg::rec_t mem_q [dop_pkg::QDepth];
	logic [dop_pkg::QAw-1:0] wr_ptr_q;
	logic [dop_pkg::QAw-1:0] rd_ptr_q;
	logic [dop_pkg::QAw:0]   count_q;
	logic [dop_pkg::QAw-1:0] wr_next;
	logic                    do_pop;

	assign not_empty = (count_q != '0);
	assign room2     = (count_q <= (dop_pkg::QAw+1)'(dop_pkg::QDepth - 2));
	assign head      = mem_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;
	assign wr_next   = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + dop_pkg::QAw'(push.cnt);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (dop_pkg::QAw+1)'(push.cnt)
				- (dop_pkg::QAw+1)'(do_pop);
		end
	end

endmodule
`default_nettype wire

[design/dhcp_option_parser.sv]
// Top level of the DHCP vendor-option parser: option walker and output queue.
//
// The parser takes the option area of a BOOTP/DHCP reply, the bytes after the
// magic cookie, one word per cycle, with last_byte set on the final byte. It
// walks the code, length and value records, skips pad bytes, and emits records
// for the subnet mask, every gateway and name-server address, every host-name
// and domain character, the message type, a nonzero server identifier and the
// lease, renewal and rebind times (all ones is reported as infinite with value
// 0; other times saturate at 65535 seconds). Every message ends with one end
// record that tells whether a message-type option was present, after which the
// parser is back in its reset state for the next message. Each accepted byte is
// fully handled in the cycle in which it is taken: the parser state registers
// update at that edge and any records go into a four-entry output queue. An
// input word is accepted every cycle as long as the queue has room for two
// records, so the sustained rate is one byte per cycle; only the final byte of
// a message can yield two records, which drain one per cycle while out_ready is high.
`default_nettype none
module dhcp_option_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  option_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       record_kind,
	output logic [31:0]      record_value,
	output logic             is_infinite,
	output logic             saw_message_type
);

	// Parser state.
	dop_pkg::phase_t phase_q, phase_d;
	logic [7:0]  code_q, code_d;
	logic [7:0]  left_q, left_d;
	logic [1:0]  grp_q, grp_d;
	logic [31:0] acc_q, acc_d;
	logic        mts_q, mts_d;
	logic        ok_q, ok_d;

	logic            accept;
	logic            room2;
	dop_pkg::push_t  push;
	dop_pkg::rec_t   head;
	dop_pkg::rec_t   data_rec;
	logic            data_v;
	logic            ended_here;
	logic            end_v;
	dop_pkg::rec_t   end_rec;

	assign in_ready = room2;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dop_pkg::PH_CODE;
			code_q  <= '0;
			left_q  <= '0;
			grp_q   <= '0;
			acc_q   <= '0;
			mts_q   <= 1'b0;
			ok_q    <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			code_q  <= code_d;
			left_q  <= left_d;
			grp_q   <= grp_d;
			acc_q   <= acc_d;
			mts_q   <= mts_d;
			ok_q    <= ok_d;
		end
	end

	// Next state and the records caused by the current input word.
	always_comb begin
		phase_d    = phase_q;
		code_d     = code_q;
		left_d     = left_q;
		grp_d      = grp_q;
		acc_d      = acc_q;
		mts_d      = mts_q;
		ok_d       = ok_q;
		data_v     = 1'b0;
		data_rec   = '0;
		ended_here = 1'b0;

		case (phase_q)
			dop_pkg::PH_CODE: begin
				if (option_byte == dop_pkg::OPT_PAD) begin
					phase_d = dop_pkg::PH_CODE;
				end else if (option_byte == dop_pkg::OPT_END) begin
					data_v        = 1'b1;
					data_rec.kind = dop_pkg::KIND_END;
					data_rec.saw  = mts_q;
					ended_here    = 1'b1;
					phase_d       = dop_pkg::PH_DONE;
				end else begin
					code_d = option_byte;
					if (option_byte == dop_pkg::OPT_MSGTYPE) begin
						mts_d = 1'b1;
					end
					phase_d = dop_pkg::PH_LEN;
				end
			end
			dop_pkg::PH_LEN: begin
				left_d = option_byte;
				grp_d  = '0;
				acc_d  = '0;
				case (code_q)
					dop_pkg::OPT_MASK:    ok_d = (option_byte >= 8'd4);
					dop_pkg::OPT_MSGTYPE: ok_d = (option_byte != 8'd0);
					dop_pkg::OPT_LEASE,
					dop_pkg::OPT_SERVER,
					dop_pkg::OPT_RENEWAL,
					dop_pkg::OPT_REBIND:  ok_d = (option_byte == 8'd4);
					default:              ok_d = 1'b0;
				endcase
				phase_d = (option_byte != 8'd0) ? dop_pkg::PH_VALUE : dop_pkg::PH_CODE;
			end
			dop_pkg::PH_VALUE: begin
				acc_d  = {acc_q[23:0], option_byte};
				grp_d  = grp_q + 2'd1;
				left_d = left_q - 8'd1;
				if (code_q == dop_pkg::OPT_HOSTNAME) begin
					data_v         = 1'b1;
					data_rec.kind  = dop_pkg::KIND_HOSTCHAR;
					data_rec.value = {24'd0, option_byte};
				end else if (code_q == dop_pkg::OPT_DOMAIN) begin
					data_v         = 1'b1;
					data_rec.kind  = dop_pkg::KIND_DOMCHAR;
					data_rec.value = {24'd0, option_byte};
				end else if (code_q == dop_pkg::OPT_MSGTYPE && ok_q) begin
					data_v         = 1'b1;
					data_rec.kind  = dop_pkg::KIND_MSGTYPE;
					data_rec.value = {24'd0, option_byte};
					ok_d           = 1'b0;
				end else if (grp_d == 2'd0) begin
					// A four-byte group has just completed.
					data_rec.value = acc_d;
					case (code_q)
						dop_pkg::OPT_MASK: begin
							data_v        = ok_q;
							data_rec.kind = dop_pkg::KIND_MASK;
							ok_d          = 1'b0;
						end
						dop_pkg::OPT_GATEWAY: begin
							data_v        = 1'b1;
							data_rec.kind = dop_pkg::KIND_GATEWAY;
						end
						dop_pkg::OPT_NSERVER: begin
							data_v        = 1'b1;
							data_rec.kind = dop_pkg::KIND_NSERVER;
						end
						dop_pkg::OPT_SERVER: begin
							data_v        = ok_q && (acc_d != 32'd0);
							data_rec.kind = dop_pkg::KIND_SERVER;
							ok_d          = 1'b0;
						end
						dop_pkg::OPT_LEASE,
						dop_pkg::OPT_RENEWAL,
						dop_pkg::OPT_REBIND: begin
							data_v = ok_q;
							ok_d   = 1'b0;
							case (code_q)
								dop_pkg::OPT_LEASE:   data_rec.kind = dop_pkg::KIND_LEASE;
								dop_pkg::OPT_RENEWAL: data_rec.kind = dop_pkg::KIND_RENEWAL;
								default:              data_rec.kind = dop_pkg::KIND_REBIND;
							endcase
							// All ones means an infinite lease; otherwise saturate.
							if (acc_d == 32'hFFFF_FFFF) begin
								data_rec.value = '0;
								data_rec.inf   = 1'b1;
							end else if (acc_d > dop_pkg::TIME_SAT) begin
								data_rec.value = dop_pkg::TIME_SAT;
							end
						end
						default: begin
							data_v = 1'b0;
						end
					endcase
				end
				if (left_d == 8'd0) begin
					phase_d = dop_pkg::PH_CODE;
				end
			end
			default: begin
				// After the end code the rest of the message is ignored.
				phase_d = dop_pkg::PH_DONE;
			end
		endcase

		// The last byte closes the message unless the end code already did so,
		// and the parser returns to its reset state.
		end_v = last_byte && !ended_here && (phase_d != dop_pkg::PH_DONE);
		end_rec      = '0;
		end_rec.kind = dop_pkg::KIND_END;
		end_rec.saw  = mts_d;
		if (last_byte) begin
			phase_d = dop_pkg::PH_CODE;
			code_d  = '0;
			left_d  = '0;
			grp_d   = '0;
			acc_d   = '0;
			mts_d   = 1'b0;
			ok_d    = 1'b0;
		end
	end

	// Pack the records of this word for the queue, data record first.
	always_comb begin
		push    = '0;
		push.r1 = end_rec;
		if (accept) begin
			if (data_v) begin
				push.r0  = data_rec;
				push.cnt = end_v ? 2'd2 : 2'd1;
			end else begin
				push.r0  = end_rec;
				push.cnt = end_v ? 2'd1 : 2'd0;
			end
		end
	end

	dop_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (out_ready),
		.head      (head),
		.not_empty (out_valid),
		.room2     (room2)
	);

	assign record_kind      = head.kind;
	assign record_value     = head.value;
	assign is_infinite      = head.inf;
	assign saw_message_type = head.saw;

endmodule
`default_nettype wire

[verif/option_record_checker.sv]
// Checker for the DHCP option parser: predicts the records from the accepted words and compares.
module option_record_checker
	import dop_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  option_byte,
	input  logic        last_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  record_kind,
	input  logic [31:0] record_value,
	input  logic        is_infinite,
	input  logic        saw_message_type,
	output int          mismatches,
	output int          outstanding
);

	// Shadow copy of the parser state.
	phase_t      phase;
	logic [7:0]  code_reg;
	logic [7:0]  left;
	logic [1:0]  grp;
	logic [31:0] acc;
	logic        mt_seen;
	logic        len_ok;

	rec_t expected_records[$];

	task automatic clear_parse_state();
		phase = PH_CODE;
		code_reg = '0;
		left = '0;
		grp = '0;
		acc = '0;
		mt_seen = 1'b0;
		len_ok = 1'b0;
	endtask

	task automatic add_record(input logic [3:0] kind, input logic [31:0] value,
			input logic inf, input logic saw);
		rec_t r;
		r.kind = kind;
		r.value = value;
		r.inf = inf;
		r.saw = saw;
		expected_records.push_back(r);
	endtask

	// An all-ones time means an infinite lease; anything else saturates.
	task automatic add_time(input logic [3:0] kind, input logic [31:0] secs);
		if (secs == '1)
			add_record(kind, '0, 1'b1, 1'b0);
		else
			add_record(kind, (secs > TIME_SAT) ? TIME_SAT : secs, 1'b0, 1'b0);
	endtask

	task automatic walk_option_byte(input logic [7:0] b, input logic last);
		logic ended_here;
		ended_here = 1'b0;
		case (phase)
		PH_CODE: begin
			if (b == OPT_END) begin
				add_record(KIND_END, '0, 1'b0, mt_seen);
				ended_here = 1'b1;
				phase = PH_DONE;
			end else if (b != OPT_PAD) begin
				code_reg = b;
				if (b == OPT_MSGTYPE)
					mt_seen = 1'b1;
				phase = PH_LEN;
			end
		end
		PH_LEN: begin
			left = b;
			grp = '0;
			acc = '0;
			case (code_reg)
			OPT_MASK:    len_ok = (b >= 8'd4);
			OPT_MSGTYPE: len_ok = (b >= 8'd1);
			OPT_LEASE, OPT_SERVER, OPT_RENEWAL, OPT_REBIND: len_ok = (b == 8'd4);
			default:     len_ok = 1'b0;
			endcase
			phase = (b != 8'd0) ? PH_VALUE : PH_CODE;
		end
		PH_VALUE: begin
			acc = {acc[23:0], b};
			grp = grp + 2'd1;
			left = left - 8'd1;
			if (code_reg == OPT_HOSTNAME) begin
				add_record(KIND_HOSTCHAR, {24'd0, b}, 1'b0, 1'b0);
			end else if (code_reg == OPT_DOMAIN) begin
				add_record(KIND_DOMCHAR, {24'd0, b}, 1'b0, 1'b0);
			end else if (code_reg == OPT_MSGTYPE && len_ok) begin
				add_record(KIND_MSGTYPE, {24'd0, b}, 1'b0, 1'b0);
				len_ok = 1'b0;
			end else if (grp == 2'd0) begin
				case (code_reg)
				OPT_MASK: begin
					if (len_ok)
						add_record(KIND_MASK, acc, 1'b0, 1'b0);
					len_ok = 1'b0;
				end
				OPT_GATEWAY: add_record(KIND_GATEWAY, acc, 1'b0, 1'b0);
				OPT_NSERVER: add_record(KIND_NSERVER, acc, 1'b0, 1'b0);
				OPT_SERVER: begin
					if (len_ok && acc != '0)
						add_record(KIND_SERVER, acc, 1'b0, 1'b0);
					len_ok = 1'b0;
				end
				OPT_LEASE: begin
					if (len_ok)
						add_time(KIND_LEASE, acc);
					len_ok = 1'b0;
				end
				OPT_RENEWAL: begin
					if (len_ok)
						add_time(KIND_RENEWAL, acc);
					len_ok = 1'b0;
				end
				OPT_REBIND: begin
					if (len_ok)
						add_time(KIND_REBIND, acc);
					len_ok = 1'b0;
				end
				default: ;
				endcase
			end
			if (left == 8'd0)
				phase = PH_CODE;
		end
		default: phase = PH_DONE;
		endcase
		if (last) begin
			if (!ended_here && phase != PH_DONE)
				add_record(KIND_END, '0, 1'b0, mt_seen);
			clear_parse_state();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rec_t want;
		if (!arst_n) begin
			clear_parse_state();
			expected_records.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready)
				walk_option_byte(option_byte, last_byte);
			if (out_valid && out_ready) begin
				if (expected_records.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected record: kind %0d value %h inf %b saw %b",
							record_kind, record_value, is_infinite, saw_message_type);
				end else begin
					want = expected_records.pop_front();
					if (want.kind !== record_kind || want.value !== record_value ||
							want.inf !== is_infinite || want.saw !== saw_message_type) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Wrong record: expected kind %0d value %h inf %b saw %b, got kind %0d value %h inf %b saw %b",
								want.kind, want.value, want.inf, want.saw,
								record_kind, record_value, is_infinite, saw_message_type);
					end
				end
			end
			outstanding <= expected_records.size();
		end
	end

endmodule

[verif/testbench.sv]
// Top of the DHCP option parser testbench: clock, reset, stimulus and verdict.
module testbench;
	import dop_pkg::*;

	// A typical message-type value (an acknowledgement) for the directed words.
	localparam logic [7:0] DHCP_ACK = 8'd5;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  option_byte = 8'd0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  record_kind;
	logic [31:0] record_value;
	logic        is_infinite;
	logic        saw_message_type;

	int mismatches;
	int outstanding;

	// Percentages of cycles in which the sender holds back and the receiver stalls.
	int tx_idle_pct = 23;
	int rx_idle_pct = 85;

	// Words of the message being built, and how many words the parser has taken.
	logic [7:0] msg[$];
	int         words_sent = 0;

	always #4 clk = ~clk;

	dhcp_option_parser dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.option_byte      (option_byte),
		.last_byte        (last_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.record_kind      (record_kind),
		.record_value     (record_value),
		.is_infinite      (is_infinite),
		.saw_message_type (saw_message_type)
	);

	option_record_checker checker_inst (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.option_byte      (option_byte),
		.last_byte        (last_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.record_kind      (record_kind),
		.record_value     (record_value),
		.is_infinite      (is_infinite),
		.saw_message_type (saw_message_type),
		.mismatches       (mismatches),
		.outstanding      (outstanding)
	);

	// The receiver decides afresh at every edge whether it will take a record.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Mostly the nominal length of the option, sometimes a short or odd one, and very
	// rarely a long one, so that the length counter is exercised over its full range.
	function automatic int vary_length(input int nominal);
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return nominal;
		else if (r < 99)
			return $urandom_range(0, 9);
		else
			return $urandom_range(10, 255);
	endfunction

	// Appends one option with a length of roughly the right size and random content.
	// Time options get values around the saturation point and the infinite pattern,
	// and the server identifier is sometimes all zeros so that it must be suppressed.
	task automatic append_option(input logic [7:0] code, input int nominal);
		int          len;
		int          i;
		logic [31:0] secs;
		len = vary_length(nominal);
		msg.push_back(code);
		msg.push_back(len[7:0]);
		if ((code == OPT_LEASE || code == OPT_RENEWAL || code == OPT_REBIND) && len == 4) begin
			case ($urandom_range(0, 4))
			0: secs = '1;
			1: secs = $urandom_range(0, 65535);
			2: secs = TIME_SAT;
			3: secs = TIME_SAT + 32'd1;
			default: secs = $urandom;
			endcase
			for (i = 3; i >= 0; i--)
				msg.push_back(secs[8*i +: 8]);
		end else if (code == OPT_SERVER && len == 4 && $urandom_range(0, 3) == 0) begin
			repeat (4) msg.push_back(8'd0);
		end else begin
			for (i = 0; i < len; i++)
				msg.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// Builds one message. Most are well-formed option lists closed by the end code,
	// some run to the last word without an end code, some are cut off in the middle
	// of an option, and a few are plain noise.
	task automatic compose_message();
		int style;
		int n;
		msg.delete();
		style = $urandom_range(0, 99);
		if (style < 10) begin
			repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 6)) begin
				case ($urandom_range(0, 12))
				0:  msg.push_back(OPT_PAD);
				1:  append_option(OPT_MASK, 4);
				2:  append_option(OPT_GATEWAY, 4 * $urandom_range(1, 3));
				3:  append_option(OPT_NSERVER, 4 * $urandom_range(1, 3));
				4:  append_option(OPT_HOSTNAME, $urandom_range(1, 8));
				5:  append_option(OPT_DOMAIN, $urandom_range(1, 8));
				6:  append_option(OPT_MSGTYPE, 1);
				7:  append_option(OPT_SERVER, 4);
				8:  append_option(OPT_LEASE, 4);
				9:  append_option(OPT_RENEWAL, 4);
				10: append_option(OPT_REBIND, 4);
				default: append_option(8'($urandom_range(1, 254)), $urandom_range(0, 6));
				endcase
			end
			if (style < 70) begin
				// Anything after the end code must be ignored until the last word.
				msg.push_back(OPT_END);
				repeat ($urandom_range(0, 2)) msg.push_back(8'($urandom_range(0, 255)));
			end else if (style < 85 && msg.size() > 1) begin
				n = $urandom_range(1, msg.size() - 1);
				repeat (n) void'(msg.pop_back());
			end
		end
	endtask

	// Offers the words of the message one after another, flagging the final one.
	// Valid stays high from one word to the next unless the sender chooses to idle.
	task automatic send_message();
		int i;
		for (i = 0; i < msg.size(); i++) begin
			while ($urandom_range(0, 99) < tx_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			option_byte <= msg[i];
			last_byte <= (i == msg.size() - 1);
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			words_sent++;
		end
	endtask

	initial begin
		int ph;
		int target;
		int start;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed messages. The first has a pad word, a message type, an infinite
		// lease, a renewal time just above the saturation limit, the end code and
		// a stray word after it. The second has a zero-length message type, which
		// must still be flagged as seen, and a subnet mask too short to report.
		msg = '{OPT_PAD, OPT_MSGTYPE, 8'd1, DHCP_ACK,
			OPT_LEASE, 8'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			OPT_RENEWAL, 8'd4, 8'h00, 8'h01, 8'h00, 8'h00,
			OPT_END, 8'hFF};
		send_message();
		msg = '{OPT_MSGTYPE, 8'd0, OPT_MASK, 8'd2, 8'hFF, 8'hFF};
		send_message();

		// Random messages in three stretches: a slow receiver, then a slow sender,
		// then both at full rate. At the end of each stretch the sender holds off
		// until every outstanding record has drained.
		start = words_sent;
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
			0: begin
				tx_idle_pct = 23;
				rx_idle_pct = 85;
			end
			1: begin
				tx_idle_pct = 85;
				rx_idle_pct = 23;
			end
			default: begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			endcase
			target = start + 167 * (ph + 1);
			while (words_sent < target) begin
				compose_message();
				send_message();
			end
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while (outstanding != 0);
		end

		// Let the queue settle before the verdict is printed.
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Safety net in case the parser stops accepting words or producing records.
	initial begin
		#2400000;
		$display("Mismatches found");
		$finish;
	end

endmodule
